[src/assert_macros.svh]
// Assertion helpers included by the controller RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked out of reset
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[src/rrtd_pkg.sv]
// ---------------------------------------------------------------------------
// rrtd_pkg
// Types and constants shared by the tick divider controller and datapath.
// ---------------------------------------------------------------------------
package rrtd_pkg;

  localparam int SCALE_W = 16;
  localparam int IVL_W   = 40;
  localparam int MODE_W  = 2;
  localparam int PD_W    = 48;
  localparam int OUT_W   = 64;
  localparam int IDX_W   = 7;
  localparam int DIV_W   = 64;
  localparam int CFG_IW  = 2;

  localparam logic [CFG_IW-1:0] CFG_SCALE    = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_INTERVAL = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_MODE     = 2'd2;

  localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLIP   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MULTI  = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MUL, ST_DISPATCH, ST_Z1, ST_Z2, ST_CWAIT, ST_NADD, ST_NCHK,
    ST_NWAIT, ST_NUPD1, ST_NUPD2, ST_MWAIT, ST_MOFF, ST_MBASE, ST_MCHK,
    ST_MLOOP, ST_MT1, ST_MT2, ST_NOTICK
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LATCH, OP_MUL, OP_ZERO1, OP_ZERO2, OP_CLIPD, OP_NADD,
    OP_NUPD1, OP_NUPD2, OP_MOFF, OP_MBASE, OP_MCHK, OP_MSTEP, OP_MT1,
    OP_MT2, OP_NOTICK
  } dp_op_t;

  typedef enum logic [1:0] {
    DIV_MAG, DIV_MAGM1, DIV_TRACK
  } div_src_t;

  typedef struct packed {
    dp_op_t   op;
    logic     div_start;
    div_src_t div_src;
    logic     load_out;
    logic     out_last;
  } cmd_t;

  typedef struct packed {
    logic              scale_zero;
    logic [MODE_W-1:0] mode;
    logic              pd_zero;
    logic              div_busy;
    logic              div_done;
    logic              out_range;
    logic              fin;
    logic              tail;
    logic              e_zero;
    logic              loop_done;
    logic              loop_end;
    logic              slot_free;
  } stat_t;

endpackage

[src/rrtd_div.sv]
// ---------------------------------------------------------------------------
// rrtd_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module rrtd_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [rrtd_pkg::DIV_W-1:0]        dividend,
  input  logic [rrtd_pkg::IVL_W-1:0]        divisor,
  output logic                              busy,
  output logic                              done,
  output logic [rrtd_pkg::DIV_W-1:0]        quot,
  output logic [rrtd_pkg::IVL_W-1:0]        rem
);

  localparam int DW = rrtd_pkg::DIV_W;
  localparam int VW = rrtd_pkg::IVL_W;
  localparam int CW = $clog2(DW);

  logic [DW-1:0] q_r, q_nxt;
  logic [VW:0]   rem_r, rem_nxt;
  logic [VW-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic [VW:0]   rem_sh;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r[VW-1:0], q_r[DW-1]};
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = rem_sh - {1'b0, dvs_r};
        q_nxt   = {q_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        q_nxt   = {q_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = q_r;
  assign rem  = rem_r[VW-1:0];

endmodule

[src/rrtd_dp.sv]
// ---------------------------------------------------------------------------
// rrtd_dp
// Datapath: configuration, timer state, shared divider and result register.
// ---------------------------------------------------------------------------
module rrtd_dp #(
  parameter int MAX_TICKS  = 64,
  parameter int TIME_WIDTH = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [rrtd_pkg::CFG_IW-1:0]        cfg_index,
  input  logic [rrtd_pkg::IVL_W-1:0]         cfg_data,
  input  logic [rrtd_pkg::PD_W-1:0]          in_parent_delta,
  input  rrtd_pkg::cmd_t                     cmd,
  output rrtd_pkg::stat_t                    st,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic                               out_ticked,
  output logic [rrtd_pkg::OUT_W-1:0]         out_cur_time,
  output logic [rrtd_pkg::OUT_W-1:0]         out_low_bound,
  output logic [rrtd_pkg::OUT_W-1:0]         out_tick_delta,
  output logic [rrtd_pkg::IDX_W-1:0]         out_tick_index,
  output logic                               out_overrun,
  output logic                               out_last
);

  localparam int TW = TIME_WIDTH;
  localparam int VW = rrtd_pkg::IVL_W;
  localparam int DW = rrtd_pkg::DIV_W;
  localparam int CW = (MAX_TICKS > 2) ? $clog2(MAX_TICKS) : 1;

  logic [rrtd_pkg::SCALE_W-1:0] scale_r;
  logic [VW-1:0]                ivl_r;
  logic [rrtd_pkg::MODE_W-1:0]  mode_r;

  logic [rrtd_pkg::PD_W-1:0] pd_r;
  logic [63:0]   mag_r;
  logic          neg_r;
  logic [TW-1:0] dlt_r, off_r;
  logic [VW:0]   remf_r;
  logic [TW-1:0] track_r, tick_r, lower_r, upper_r, last_r;
  logic [TW-1:0] track_nxt, tick_nxt, lower_nxt, upper_nxt, last_nxt;
  logic [TW-1:0] trkb_r, lowb_r, uppb_r, trkf_r;
  logic          fin_r, tail_r, nmax_r, big_r;
  logic [CW-1:0] e_r, cnt_r;

  logic [VW-1:0]   ivl_eff, r_n, div_rem;
  logic [TW-1:0]   ivl_t, stp, rem_t, r_t, remf_t, pd_t, offs, trkf;
  logic [TW+VW:0]  ext_tmp;
  logic            div_busy, div_done;
  logic [DW-1:0]   div_q, div_a;
  logic signed [63:0] prod_c;

  assign ivl_eff = (ivl_r == '0) ? VW'(1) : ivl_r;

  // Bring a 41-bit value into the time width, truncating or extending
  function automatic logic [TW-1:0] to_tw(input logic [VW:0] v);
    logic [TW+VW:0] t;
    t = {{TW{1'b0}}, v};
    return t[TW-1:0];
  endfunction

  assign ext_tmp = '0;
  assign ivl_t  = to_tw({1'b0, ivl_eff}) | ext_tmp[TW-1:0];
  assign stp    = neg_r ? (TW'(0) - ivl_t) : ivl_t;
  assign rem_t  = to_tw({1'b0, div_rem});
  assign remf_t = to_tw(remf_r);
  assign r_n    = (track_r[TW-1] && div_rem != '0) ? (ivl_eff - div_rem) :
                  (track_r[TW-1] ? '0 : div_rem);
  assign r_t    = to_tw({1'b0, r_n});
  assign pd_t   = TW'(64'($signed(pd_r)));
  assign offs   = neg_r ? (TW'(0) - off_r) : off_r;
  assign trkf   = neg_r ? (trkb_r - remf_t) : (trkb_r + remf_t);
  assign prod_c = $signed(pd_r) * $signed({1'b0, scale_r});

  always_comb begin
    unique case (cmd.div_src)
      rrtd_pkg::DIV_MAG:   div_a = mag_r;
      rrtd_pkg::DIV_MAGM1: div_a = mag_r - 64'd1;
      default:   div_a = track_r[TW-1] ? DW'(TW'(0) - track_r) : DW'(track_r);
    endcase
  end

  rrtd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (ivl_eff),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= '0;
      ivl_r   <= VW'(1);
      mode_r  <= rrtd_pkg::MODE_NORMAL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rrtd_pkg::CFG_SCALE:    scale_r <= cfg_data[rrtd_pkg::SCALE_W-1:0];
        rrtd_pkg::CFG_INTERVAL: ivl_r   <= cfg_data;
        rrtd_pkg::CFG_MODE:     mode_r  <= cfg_data[rrtd_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Timer state update
  always_comb begin
    track_nxt = track_r;
    tick_nxt  = tick_r;
    lower_nxt = lower_r;
    upper_nxt = upper_r;
    last_nxt  = last_r;
    unique case (cmd.op)
      rrtd_pkg::OP_ZERO1: begin
        last_nxt  = pd_t;
        tick_nxt  = tick_r + pd_t;
        lower_nxt = tick_r + pd_t;
      end
      rrtd_pkg::OP_ZERO2, rrtd_pkg::OP_NUPD2: upper_nxt = lower_r + ivl_t;
      rrtd_pkg::OP_NADD: track_nxt = track_r + dlt_r;
      rrtd_pkg::OP_NUPD1: begin
        lower_nxt = track_r - r_t;
        last_nxt  = track_r - tick_r;
        tick_nxt  = track_r;
      end
      rrtd_pkg::OP_MSTEP: begin
        track_nxt = track_r + stp;
        lower_nxt = lower_r + stp;
        upper_nxt = upper_r + stp;
        tick_nxt  = track_r + stp;
        last_nxt  = stp;
      end
      rrtd_pkg::OP_MT1: begin
        track_nxt = trkb_r;
        lower_nxt = lowb_r;
        upper_nxt = uppb_r;
        if (tail_r) begin
          tick_nxt = trkb_r;
          last_nxt = stp;
        end
      end
      rrtd_pkg::OP_MT2: begin
        track_nxt = trkf_r;
        if (fin_r) begin
          last_nxt = trkf_r - tick_r;
          tick_nxt = trkf_r;
          if (neg_r) begin
            upper_nxt = lower_r;
            lower_nxt = lower_r - ivl_t;
          end else begin
            lower_nxt = upper_r;
            upper_nxt = upper_r + ivl_t;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_r <= '0;
      tick_r  <= '0;
      lower_r <= '0;
      upper_r <= TW'(1);
      last_r  <= '0;
    end else begin
      track_r <= track_nxt;
      tick_r  <= tick_nxt;
      lower_r <= lower_nxt;
      upper_r <= upper_nxt;
      last_r  <= last_nxt;
    end
  end

  // Per-item working registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      rrtd_pkg::OP_LATCH: pd_r <= in_parent_delta;
      rrtd_pkg::OP_MUL: begin
        mag_r  <= prod_c[63] ? (64'd0 - prod_c) : prod_c;
        neg_r  <= pd_r[rrtd_pkg::PD_W-1];
        dlt_r  <= prod_c[TW-1:0];
      end
      rrtd_pkg::OP_CLIPD: dlt_r <= neg_r ? (TW'(0) - rem_t) : rem_t;
      rrtd_pkg::OP_MOFF: begin
        off_r  <= TW'(mag_r - 64'(div_rem) - 64'd1);
        remf_r <= {1'b0, div_rem} + 1'b1;
        tail_r <= div_q > 64'(MAX_TICKS - 1);
        big_r  <= div_q > 64'(MAX_TICKS);
        nmax_r <= div_q == 64'(MAX_TICKS);
        e_r    <= (div_q > 64'(MAX_TICKS - 1)) ? CW'(MAX_TICKS - 1) : div_q[CW-1:0];
      end
      rrtd_pkg::OP_MBASE: begin
        trkb_r <= track_r + offs;
        lowb_r <= lower_r + offs;
        uppb_r <= upper_r + offs;
      end
      rrtd_pkg::OP_MCHK: begin
        trkf_r <= trkf;
        fin_r  <= neg_r ? ($signed(trkf) < $signed(lowb_r)) :
                          !($signed(trkf) < $signed(uppb_r));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.op == rrtd_pkg::OP_MOFF) begin
      cnt_r <= '0;
    end else if (cmd.op == rrtd_pkg::OP_MSTEP) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Result register: load from the state as it stands after this result
  logic out_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.load_out) begin
      out_cur_time   <= 64'($signed(tick_nxt));
      out_low_bound  <= 64'($signed(lower_nxt));
      out_tick_delta <= 64'($signed(last_nxt));
      out_last       <= cmd.out_last;
      out_overrun    <= 1'b0;
      unique case (cmd.op)
        rrtd_pkg::OP_NOTICK: begin
          out_ticked     <= 1'b0;
          out_tick_index <= '0;
        end
        rrtd_pkg::OP_MSTEP: begin
          out_ticked     <= 1'b1;
          out_tick_index <= rrtd_pkg::IDX_W'({1'b0, cnt_r} + 1'b1);
        end
        rrtd_pkg::OP_MT2: begin
          out_ticked     <= 1'b1;
          out_tick_index <= rrtd_pkg::IDX_W'({1'b0, e_r} + 1'b1);
          out_overrun    <= big_r || (nmax_r && fin_r);
        end
        default: begin
          out_ticked     <= 1'b1;
          out_tick_index <= rrtd_pkg::IDX_W'(1);
        end
      endcase
    end
  end
  assign out_valid = out_valid_r;

  assign st.scale_zero = (scale_r == '0);
  assign st.mode       = mode_r;
  assign st.pd_zero    = (pd_r == '0);
  assign st.div_busy   = div_busy;
  assign st.div_done   = div_done;
  assign st.out_range  = !($signed(track_r) < $signed(upper_r)) ||
                         ($signed(track_r) < $signed(lower_r));
  assign st.fin        = fin_r;
  assign st.tail       = tail_r;
  assign st.e_zero     = (e_r == '0);
  assign st.loop_done  = (cnt_r == e_r);
  assign st.loop_end   = ({1'b0, cnt_r} + 1'b1) == {1'b0, e_r};
  assign st.slot_free  = !out_valid_r || out_ready;

endmodule

[src/rrtd_ctrl.sv]
// ---------------------------------------------------------------------------
// rrtd_ctrl
// Controller: sequences one item through multiply, divide and tick emission.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rrtd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  rrtd_pkg::stat_t  st,
  output rrtd_pkg::cmd_t   cmd
);

  rrtd_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rrtd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd.op        = rrtd_pkg::OP_NONE;
    cmd.div_start = 1'b0;
    cmd.div_src   = rrtd_pkg::DIV_MAG;
    cmd.load_out  = 1'b0;
    cmd.out_last  = 1'b0;
    in_ready      = (state_r == rrtd_pkg::ST_IDLE);
    unique case (state_r)
      rrtd_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = rrtd_pkg::OP_LATCH;
          state_nxt = rrtd_pkg::ST_MUL;
        end
      end
      rrtd_pkg::ST_MUL: begin
        cmd.op    = rrtd_pkg::OP_MUL;
        state_nxt = rrtd_pkg::ST_DISPATCH;
      end
      rrtd_pkg::ST_DISPATCH: begin
        priority if (st.scale_zero) begin
          state_nxt = rrtd_pkg::ST_Z1;
        end else if (st.mode == rrtd_pkg::MODE_MULTI) begin
          if (st.pd_zero) begin
            state_nxt = rrtd_pkg::ST_NOTICK;
          end else begin
            cmd.div_start = 1'b1;
            cmd.div_src   = rrtd_pkg::DIV_MAGM1;
            state_nxt     = rrtd_pkg::ST_MWAIT;
          end
        end else if (st.mode == rrtd_pkg::MODE_CLIP) begin
          cmd.div_start = 1'b1;
          state_nxt     = rrtd_pkg::ST_CWAIT;
        end else begin
          state_nxt = rrtd_pkg::ST_NADD;
        end
      end
      rrtd_pkg::ST_Z1: begin
        cmd.op    = rrtd_pkg::OP_ZERO1;
        state_nxt = rrtd_pkg::ST_Z2;
      end
      rrtd_pkg::ST_Z2: begin
        if (st.slot_free) begin
          cmd.op       = rrtd_pkg::OP_ZERO2;
          cmd.load_out = 1'b1;
          cmd.out_last = 1'b1;
          state_nxt    = rrtd_pkg::ST_IDLE;
        end
      end
      rrtd_pkg::ST_CWAIT: begin
        if (st.div_done) begin
          cmd.op    = rrtd_pkg::OP_CLIPD;
          state_nxt = rrtd_pkg::ST_NADD;
        end
      end
      rrtd_pkg::ST_NADD: begin
        cmd.op    = rrtd_pkg::OP_NADD;
        state_nxt = rrtd_pkg::ST_NCHK;
      end
      rrtd_pkg::ST_NCHK: begin
        if (st.out_range) begin
          cmd.div_start = 1'b1;
          cmd.div_src   = rrtd_pkg::DIV_TRACK;
          state_nxt     = rrtd_pkg::ST_NWAIT;
        end else begin
          state_nxt = rrtd_pkg::ST_NOTICK;
        end
      end
      rrtd_pkg::ST_NWAIT: begin
        if (st.div_done) state_nxt = rrtd_pkg::ST_NUPD1;
      end
      rrtd_pkg::ST_NUPD1: begin
        cmd.op    = rrtd_pkg::OP_NUPD1;
        state_nxt = rrtd_pkg::ST_NUPD2;
      end
      rrtd_pkg::ST_NUPD2: begin
        if (st.slot_free) begin
          cmd.op       = rrtd_pkg::OP_NUPD2;
          cmd.load_out = 1'b1;
          cmd.out_last = 1'b1;
          state_nxt    = rrtd_pkg::ST_IDLE;
        end
      end
      rrtd_pkg::ST_MWAIT: begin
        if (st.div_done) state_nxt = rrtd_pkg::ST_MOFF;
      end
      rrtd_pkg::ST_MOFF: begin
        cmd.op    = rrtd_pkg::OP_MOFF;
        state_nxt = rrtd_pkg::ST_MBASE;
      end
      rrtd_pkg::ST_MBASE: begin
        cmd.op    = rrtd_pkg::OP_MBASE;
        state_nxt = rrtd_pkg::ST_MCHK;
      end
      rrtd_pkg::ST_MCHK: begin
        cmd.op    = rrtd_pkg::OP_MCHK;
        state_nxt = rrtd_pkg::ST_MLOOP;
      end
      rrtd_pkg::ST_MLOOP: begin
        if (st.loop_done) begin
          state_nxt = rrtd_pkg::ST_MT1;
        end else if (st.slot_free) begin
          cmd.op       = rrtd_pkg::OP_MSTEP;
          cmd.load_out = 1'b1;
          cmd.out_last = st.loop_end && !st.tail && !st.fin;
        end
      end
      rrtd_pkg::ST_MT1: begin
        cmd.op    = rrtd_pkg::OP_MT1;
        state_nxt = rrtd_pkg::ST_MT2;
      end
      rrtd_pkg::ST_MT2: begin
        priority if (st.tail || st.fin) begin
          if (st.slot_free) begin
            cmd.op       = rrtd_pkg::OP_MT2;
            cmd.load_out = 1'b1;
            cmd.out_last = 1'b1;
            state_nxt    = rrtd_pkg::ST_IDLE;
          end
        end else if (st.e_zero) begin
          // advance the tracked time by the remainder before the no-tick result
          cmd.op    = rrtd_pkg::OP_MT2;
          state_nxt = rrtd_pkg::ST_NOTICK;
        end else begin
          cmd.op    = rrtd_pkg::OP_MT2;
          state_nxt = rrtd_pkg::ST_IDLE;
        end
      end
      rrtd_pkg::ST_NOTICK: begin
        if (st.slot_free) begin
          cmd.op       = rrtd_pkg::OP_NOTICK;
          cmd.load_out = 1'b1;
          cmd.out_last = 1'b1;
          state_nxt    = rrtd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rrtd_pkg::ST_IDLE;
    endcase
  end

  `ASSERT_IMPL(a_load_slot, cmd.load_out, st.slot_free)
  `ASSERT_IMPL(a_start_idle, cmd.div_start, !st.div_busy)
  `ASSERT_NEXT(a_accept_busy, in_valid && in_ready, state_r == rrtd_pkg::ST_MUL)
  `ASSERT_IMPL(a_idle_no_div, state_r == rrtd_pkg::ST_IDLE, !st.div_busy)

endmodule

[src/rational_rate_tick_divider.sv]
// Division: the 64-step divider runs for clip, for a normal-mode tick and for multi-step; a clip
//   that ticks runs it twice.
// Throughput: one item at a time; multi-step emits its ticks one by one after the divide.
// Reset: synchronous, active low; timer state cleared, upper edge and interval set to one.
// ---------------------------------------------------------------------------
// rational_rate_tick_divider
// Fractional-rate tick generator: scaled parent deltas advance a timer that
// reports ticks on interval crossings in normal, clip or multi-step mode.
// ---------------------------------------------------------------------------
module rational_rate_tick_divider #(
  parameter int MAX_TICKS  = 64,
  parameter int TIME_WIDTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [rrtd_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [rrtd_pkg::IVL_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rrtd_pkg::PD_W-1:0]     in_parent_delta,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_ticked,
  output logic [rrtd_pkg::OUT_W-1:0]    out_cur_time,
  output logic [rrtd_pkg::OUT_W-1:0]    out_low_bound,
  output logic [rrtd_pkg::OUT_W-1:0]    out_tick_delta,
  output logic [rrtd_pkg::IDX_W-1:0]    out_tick_index,
  output logic                          out_overrun,
  output logic                          out_last
);

  rrtd_pkg::cmd_t  cmd;
  rrtd_pkg::stat_t st;

  rrtd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  rrtd_dp #(
    .MAX_TICKS  (MAX_TICKS),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_parent_delta (in_parent_delta),
    .cmd             (cmd),
    .st              (st),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_ticked      (out_ticked),
    .out_cur_time    (out_cur_time),
    .out_low_bound   (out_low_bound),
    .out_tick_delta  (out_tick_delta),
    .out_tick_index  (out_tick_index),
    .out_overrun     (out_overrun),
    .out_last        (out_last)
  );

endmodule
